// ===== rtl/gcss_pkg.sv =====
`timescale 1ns / 1ps
package gcss_pkg;

    localparam int MAX_CLUSTER_SIZE = 64;
    localparam int MEASURED_COUNT   = 19;
    localparam int POS_W            = 6;   // search position, sizes 1..63 probed
    localparam int IDX_W            = 7;   // table index 0..64
    localparam int SIZE_W           = 7;
    localparam int FRAC_W           = 17;
    localparam int W_W              = 24;  // per-shape weight
    localparam int WT_W             = 25;  // total weight
    localparam int CDF_W            = 33;  // Q32, 1.0 = 2^32
    localparam int TGT_W            = 57;
    localparam int SUM_W            = 58;
    localparam int CFG_ADDR_W       = 2;
    localparam logic [FRAC_W:0] FRAC_ONE = 18'd65536;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ARGON     = 2'd0,
        CFG_CF4       = 2'd1,
        CFG_ISOBUTANE = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [W_W-1:0]   wa;
        logic [W_W-1:0]   wm;
        logic [POS_W-1:0] pos;
        logic             status;
    } item_t;

    typedef logic [CDF_W-1:0] cdf_table_t [0:MAX_CLUSTER_SIZE];
    typedef logic [16:0] meas_table_t [0:MEASURED_COUNT-1];

    localparam meas_table_t ARGON_MEAS = '{
        17'd65600, 17'd15000, 17'd6400, 17'd3500, 17'd2250, 17'd1550, 17'd1050,
        17'd810, 17'd610, 17'd490, 17'd390, 17'd300, 17'd250, 17'd200,
        17'd160, 17'd120, 17'd95, 17'd75, 17'd63};

    localparam meas_table_t METHANE_MEAS = '{
        17'd78600, 17'd12000, 17'd3400, 17'd1600, 17'd950, 17'd600, 17'd440,
        17'd340, 17'd270, 17'd210, 17'd170, 17'd130, 17'd100, 17'd80,
        17'd60, 17'd50, 17'd42, 17'd37, 17'd33};

    // shift and subtract long division, only used while the constant tables are built
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // measured cumulative part rounded to Q32, then a 1/n^2 tail up to one
    function automatic cdf_table_t build_shape(input logic methane);
        cdf_table_t  cdf;
        logic [63:0] one;
        logic [63:0] cum5;
        logic [63:0] cmeas;
        logic [63:0] rem;
        logic [63:0] ttot;
        logic [63:0] t;
        logic [63:0] nsq;
        one   = 64'h1_0000_0000;
        cum5  = '0;
        cmeas = '0;
        ttot  = '0;
        t     = '0;
        cdf[0] = '0;
        for (int n = 1; n <= MEASURED_COUNT; n++) begin
            cum5 = cum5 + 64'(methane ? METHANE_MEAS[n-1] : ARGON_MEAS[n-1]);
            cmeas = div_u64(cum5 * one + 64'd50000, 64'd100000);
            cdf[n] = CDF_W'(cmeas);
        end
        rem = (cmeas < one) ? one - cmeas : 64'd0;
        for (int n = MEASURED_COUNT + 1; n <= MAX_CLUSTER_SIZE; n++) begin
            nsq  = 64'(n) * 64'(n);
            ttot = ttot + div_u64(one, nsq);
        end
        for (int n = MEASURED_COUNT + 1; n <= MAX_CLUSTER_SIZE; n++) begin
            nsq = 64'(n) * 64'(n);
            t   = t + div_u64(one, nsq);
            cdf[n] = CDF_W'(cmeas + div_u64(rem * t, ttot));
        end
        cdf[MAX_CLUSTER_SIZE] = CDF_W'(one);
        return cdf;
    endfunction

    localparam cdf_table_t ARGON_CDF   = build_shape(1'b0);
    localparam cdf_table_t METHANE_CDF = build_shape(1'b1);

endpackage

// ===== rtl/gcss_front.sv =====
`timescale 1ns / 1ps
module gcss_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [31:0]                 uniform_value,
    input  logic [gcss_pkg::FRAC_W-1:0] argon_fraction,
    input  logic [gcss_pkg::FRAC_W-1:0] cf4_fraction,
    input  logic [gcss_pkg::FRAC_W-1:0] isobutane_fraction,
    output logic                        out_valid,
    output gcss_pkg::item_t             out_item
);

    logic                         v1_reg;
    logic                         v2_reg;
    logic [31:0]                  u_reg;
    logic [gcss_pkg::W_W-1:0]     wa_reg, wa_next;
    logic [gcss_pkg::W_W-1:0]     wm_reg, wm_next;
    logic [gcss_pkg::WT_W-1:0]    wt_reg, wt_next;
    logic                         st_reg, st_next;
    gcss_pkg::item_t              item_reg, item_next;

    always_comb begin
        wa_next = gcss_pkg::W_W'(argon_fraction) * gcss_pkg::W_W'(23)
                + gcss_pkg::W_W'(cf4_fraction) * gcss_pkg::W_W'(51);
        wm_next = gcss_pkg::W_W'(isobutane_fraction) * gcss_pkg::W_W'(84);
        wt_next = gcss_pkg::WT_W'(wa_next) + gcss_pkg::WT_W'(wm_next);
        // all weights zero: fall back to the argon shape alone
        if (wt_next == '0) begin
            wa_next = gcss_pkg::W_W'(1);
            wt_next = gcss_pkg::WT_W'(1);
        end
        // sum of three register maxima needs two bits above the fraction width
        st_next = ((gcss_pkg::FRAC_W+2)'(argon_fraction)
                 + (gcss_pkg::FRAC_W+2)'(cf4_fraction)
                 + (gcss_pkg::FRAC_W+2)'(isobutane_fraction))
                 != (gcss_pkg::FRAC_W+2)'(gcss_pkg::FRAC_ONE);
    end

    always_comb begin
        item_next.target = gcss_pkg::TGT_W'(u_reg) * gcss_pkg::TGT_W'(wt_reg);
        item_next.wa     = wa_reg;
        item_next.wm     = wm_reg;
        item_next.pos    = '0;
        item_next.status = st_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg    <= uniform_value;
            wa_reg   <= wa_next;
            wm_reg   <= wm_next;
            wt_reg   <= wt_next;
            st_reg   <= st_next;
            item_reg <= item_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/gcss_step.sv =====
`timescale 1ns / 1ps
module gcss_step #(
    parameter int BIT = 5
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  gcss_pkg::item_t in_item,
    output logic            out_valid,
    output gcss_pkg::item_t out_item
);

    logic                          va_reg;
    logic                          vb_reg;
    gcss_pkg::item_t               ia_reg;
    gcss_pkg::item_t               ib_reg, ib_next;
    logic [gcss_pkg::POS_W-1:0]    probe;
    logic [gcss_pkg::POS_W-1:0]    probe_reg;
    logic [gcss_pkg::TGT_W-1:0]    pa_reg;
    logic [gcss_pkg::TGT_W-1:0]    pm_reg;
    logic [gcss_pkg::SUM_W-1:0]    mix;

    assign probe = in_item.pos | gcss_pkg::POS_W'(1 << BIT);

    always_comb begin
        mix     = gcss_pkg::SUM_W'(pa_reg) + gcss_pkg::SUM_W'(pm_reg);
        ib_next = ia_reg;
        // mixed cdf still below the variate: the answer lies above the probe
        if (mix < gcss_pkg::SUM_W'(ia_reg.target)) begin
            ib_next.pos = probe_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ia_reg    <= in_item;
            probe_reg <= probe;
            pa_reg    <= gcss_pkg::TGT_W'(in_item.wa)
                       * gcss_pkg::TGT_W'(gcss_pkg::ARGON_CDF[gcss_pkg::IDX_W'(probe)]);
            pm_reg    <= gcss_pkg::TGT_W'(in_item.wm)
                       * gcss_pkg::TGT_W'(gcss_pkg::METHANE_CDF[gcss_pkg::IDX_W'(probe)]);
            ib_reg    <= ib_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_item  = ib_reg;

endmodule

// ===== rtl/gas_mixture_cluster_size_sampler.sv =====
`timescale 1ns / 1ps
// Cluster size sampler for a gas mixture.
// s_ channel: one uniform variate per transaction, s_tdata = uniform_value (Q0.32).
// m_ channel: one result per variate, m_tdata bits [6:0] cluster_size (1..64),
//   bit [7] status (set when the three gas fractions do not sum to one).
// cfg_wr_en/cfg_addr/cfg_wdata write the argon, CF4 and isobutane fractions
//   (Q1.16, index 0..2); write only while no variate is in flight.
// The pipeline takes one variate per cycle unless stalled by m_tready. There are
//   fifteen register stages, the first loaded at the accepting edge: two front
//   stages (weights, then the target product), six binary-search steps of two
//   stages each (a table multiply, then a compare) and the output register.
// The whole pipeline advances together: while m_tvalid is high and m_tready
//   low, s_tready is low and every stage holds its contents.
// Reset clears all valid bits and sets the fractions to pure argon.
module gas_mixture_cluster_size_sampler (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [31:0] uniform_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [6:0] cluster_size, [7] status
    input  logic                             cfg_wr_en,
    input  logic [gcss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gcss_pkg::FRAC_W-1:0]      cfg_wdata
);

    localparam int STEPS = gcss_pkg::POS_W;

    logic                         adv;
    logic [gcss_pkg::FRAC_W-1:0]  argon_reg;
    logic [gcss_pkg::FRAC_W-1:0]  cf4_reg;
    logic [gcss_pkg::FRAC_W-1:0]  iso_reg;
    logic                         chain_valid [0:STEPS];
    gcss_pkg::item_t              chain_item  [0:STEPS];
    logic                         m_valid_reg;
    logic [7:0]                   m_data_reg, m_data_next;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            argon_reg <= gcss_pkg::FRAC_W'(gcss_pkg::FRAC_ONE);
            cf4_reg   <= '0;
            iso_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gcss_pkg::CFG_ARGON:     argon_reg <= cfg_wdata;
                gcss_pkg::CFG_CF4:       cf4_reg   <= cfg_wdata;
                gcss_pkg::CFG_ISOBUTANE: iso_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    gcss_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .adv                (adv),
        .in_valid           (s_tvalid),
        .uniform_value      (s_tdata),
        .argon_fraction     (argon_reg),
        .cf4_fraction       (cf4_reg),
        .isobutane_fraction (iso_reg),
        .out_valid          (chain_valid[0]),
        .out_item           (chain_item[0])
    );

    // most significant probe first
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        gcss_step #(.BIT(STEPS - 1 - g)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    always_comb begin
        m_data_next[6:0] = gcss_pkg::SIZE_W'(chain_item[STEPS].pos) + gcss_pkg::SIZE_W'(1);
        m_data_next[7]   = chain_item[STEPS].status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= chain_valid[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    a_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] != 7'd0 && m_tdata[6:0] <= 7'd64))
        else $error("cluster size out of range");

    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

// ===== tb/tb_gas_mixture_cluster_size_sampler.sv =====
`timescale 1ns / 1ps
module tb_gas_mixture_cluster_size_sampler;

    localparam logic [gcss_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;   // unmapped register index
    localparam int LATENCY    = 15;
    localparam int CYCLE_CAP  = 400000;
    localparam int STALL_LEN  = 200;

    typedef struct packed {
        logic [6:0] size;
        logic       status;
    } sample_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [31:0]                     s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;
    logic                            cfg_wr_en;
    logic [gcss_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [gcss_pkg::FRAC_W-1:0]     cfg_wdata;

    gas_mixture_cluster_size_sampler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    logic [63:0] argon_cum   [0:gcss_pkg::MAX_CLUSTER_SIZE];
    logic [63:0] methane_cum [0:gcss_pkg::MAX_CLUSTER_SIZE];
    logic [gcss_pkg::FRAC_W-1:0] frac_ar, frac_cf, frac_ib;

    logic [31:0] variates [$];
    sample_t     samples_due [$];
    int errors, n_results, n_sent, cycles;
    int gap_left, hold_left;
    bit no_gaps, stall_done, long_hold_req;

    // cumulative shape: rounded measured part, then a 1/n^2 tail normalised to one
    function automatic void fill_shape(input bit methane);
        logic [63:0] one, acc, base, rest, tail_sum, tail_run;
        one = 64'h1_0000_0000;
        acc = 0;
        base = 0;
        tail_sum = 0;
        tail_run = 0;
        for (int n = 1; n <= gcss_pkg::MEASURED_COUNT; n++) begin
            acc += 64'(methane ? gcss_pkg::METHANE_MEAS[n-1] : gcss_pkg::ARGON_MEAS[n-1]);
            base = (acc * one + 64'd50000) / 64'd100000;
            if (methane) methane_cum[n] = base; else argon_cum[n] = base;
        end
        rest = (base < one) ? one - base : 0;
        for (int n = gcss_pkg::MEASURED_COUNT + 1; n <= gcss_pkg::MAX_CLUSTER_SIZE; n++)
            tail_sum += one / (64'(n) * 64'(n));
        for (int n = gcss_pkg::MEASURED_COUNT + 1; n <= gcss_pkg::MAX_CLUSTER_SIZE; n++) begin
            tail_run += one / (64'(n) * 64'(n));
            if (methane) methane_cum[n] = base + rest * tail_run / tail_sum;
            else argon_cum[n] = base + rest * tail_run / tail_sum;
        end
        if (methane) methane_cum[gcss_pkg::MAX_CLUSTER_SIZE] = one;
        else argon_cum[gcss_pkg::MAX_CLUSTER_SIZE] = one;
    endfunction

    function automatic sample_t draw_size(input logic [31:0] u);
        logic [63:0] w_ar, w_me, w_all, goal;
        sample_t r;
        w_ar = 23 * 64'(frac_ar) + 51 * 64'(frac_cf);
        w_me = 84 * 64'(frac_ib);
        w_all = w_ar + w_me;
        if (w_all == 0) begin
            w_ar = 1;
            w_me = 0;
            w_all = 1;
        end
        goal = 64'(u) * w_all;
        r.size = 7'(gcss_pkg::MAX_CLUSTER_SIZE);
        for (int n = gcss_pkg::MAX_CLUSTER_SIZE; n >= 1; n--)
            if (w_ar * argon_cum[n] + w_me * methane_cum[n] >= goal) r.size = 7'(n);
        r.status = (64'(frac_ar) + 64'(frac_cf) + 64'(frac_ib) != 64'd65536);
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (no_gaps || k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata  <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                samples_due.push_back(draw_size(s_tdata));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 0;
                end else if (variates.size() > 0) begin
                    s_tdata  <= variates.pop_front();
                    s_tvalid <= 1;
                    gap_left <= pick_gap();
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            m_tready  <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (samples_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, m_tdata);
                end else begin
                    want = samples_due.pop_front();
                    if (m_tdata[6:0] !== want.size) begin
                        errors++;
                        $display("%0t: cluster_size expected %0d actual %0d",
                                 $time, want.size, m_tdata[6:0]);
                    end
                    if (m_tdata[7] !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[7]);
                    end
                end
            end
            if (long_hold_req && !stall_done) begin
                stall_done <= 1;
                hold_left  <= STALL_LEN;
                m_tready   <= 0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 0;
            end else if (no_gaps) begin
                m_tready <= 1;
            end else begin
                int k;
                k = $urandom_range(0, 99);
                m_tready <= (k >= 30);
                if (k < 3) hold_left <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [gcss_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [gcss_pkg::FRAC_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == gcss_pkg::CFG_ARGON) frac_ar = val;
        else if (idx == gcss_pkg::CFG_CF4) frac_cf = val;
        else if (idx == gcss_pkg::CFG_ISOBUTANE) frac_ib = val;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic drain();
        while (variates.size() > 0 || s_tvalid || samples_due.size() > 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_mix(input int a, input int c, input int i);
        drain();
        write_reg(gcss_pkg::CFG_ARGON, gcss_pkg::FRAC_W'(a));
        write_reg(gcss_pkg::CFG_CF4, gcss_pkg::FRAC_W'(c));
        write_reg(gcss_pkg::CFG_ISOBUTANE, gcss_pkg::FRAC_W'(i));
    endtask

    task automatic queue_random(input int count);
        int k;
        for (int j = 0; j < count; j++) begin
            k = $urandom_range(0, 2);
            // a third land in the far tail so the large sizes are reached
            if (k == 0) variates.push_back(32'hFFFF_FFFF - $urandom_range(0, 32'h0400_0000));
            else variates.push_back($urandom);
        end
    endtask

    initial begin
        int pts [6];
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_addr = gcss_pkg::CFG_ARGON;
        cfg_wdata = 0;
        errors = 0;
        n_results = 0;
        n_sent = 0;
        cycles = 0;
        no_gaps = 0;
        stall_done = 0;
        long_hold_req = 0;
        fill_shape(1'b0);
        fill_shape(1'b1);
        frac_ar = 65536;
        frac_cf = 0;
        frac_ib = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        // directed: field extremes and the step boundaries of the argon shape
        pts = '{1, 2, 19, 20, 40, 63};
        variates.push_back(32'h0000_0000);
        variates.push_back(32'hFFFF_FFFF);
        variates.push_back(32'h0000_0001);
        variates.push_back(32'h8000_0000);
        variates.push_back(32'hAAAA_AAAA);
        variates.push_back(32'h5555_5555);
        foreach (pts[j]) begin
            variates.push_back(32'(argon_cum[pts[j]] - 1));
            variates.push_back(32'(argon_cum[pts[j]]));
            variates.push_back(32'(argon_cum[pts[j]] + 1));
        end
        queue_random(40);

        // long receiver hold while the sender keeps offering
        drain();
        no_gaps = 1;
        queue_random(60);
        long_hold_req = 1;
        drain();
        no_gaps = 0;

        set_mix(0, 0, 65536);           // pure isobutane
        variates.push_back(32'(methane_cum[1]));
        variates.push_back(32'(methane_cum[1] + 1));
        variates.push_back(32'hFFFF_FFFF);
        queue_random(60);
        set_mix(0, 65536, 0);           // pure cf4
        queue_random(50);
        set_mix(0, 0, 0);               // no gas at all
        queue_random(50);
        set_mix(32768, 16384, 16384);   // proper mixture
        queue_random(60);
        set_mix(131071, 131071, 131071);// register maxima, sum far above one
        queue_random(50);
        set_mix(131071, 131071, 65538); // sum is one plus four times 65536
        queue_random(20);
        set_mix(65535, 0, 0);           // one lsb short of one
        queue_random(40);
        drain();
        write_reg(CFG_SPARE, 17'h1FFFF);// must be ignored
        queue_random(30);
        for (int p = 0; p < 3; p++) begin
            set_mix($urandom_range(0, 65536), $urandom_range(0, 65536),
                    $urandom_range(0, 65536));
            no_gaps = (p == 1);
            queue_random(30);
        end
        drain();
        no_gaps = 0;

        $display("sent %0d variates, checked %0d cluster sizes over pure, mixed,",
                 n_sent, n_results);
        $display("empty and over-full gas settings, with stalls on both sides");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
